@@ rtl/drl_pkg.sv @@
// shared constants, types and color helpers for the road layer renderer
package drl_pkg;

  localparam int RAM_WORDS  = 2048;
  localparam int RAM_AW     = $clog2(RAM_WORDS);
  localparam int BANK_DEPTH = 2 * RAM_WORDS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int ROM_BYTES  = 65536;
  localparam int ROM_DEPTH  = 65536;
  localparam int ROM_AW     = $clog2(ROM_DEPTH);
  localparam int LINE_WIDTH = 320;

  // second road line base sits in the upper half only when the rom has one
  localparam logic ROM_HI = (ROM_BYTES > 32768) ? 1'b1 : 1'b0;

  localparam logic [11:0] SCROLL_BASE = 12'h5f8;

  typedef enum logic [1:0] {
    CMD_WRITE_RAM = 2'd0,
    CMD_SWAP      = 2'd1,
    CMD_LOAD_ROM  = 2'd2,
    CMD_RENDER    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_ROAD0       = 2'd0,
    MODE_ROAD0_FRONT = 2'd1,
    MODE_ROAD1_FRONT = 2'd2,
    MODE_ROAD1       = 2'd3
  } mode_t;

  localparam logic REG_CONTROL = 1'b0;
  localparam logic REG_XOFFSET = 1'b1;

  localparam logic [7:0] PRIO_ROAD0_FRONT [8] = '{8'h80, 8'h81, 8'h81, 8'h87,
                                                  8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] PRIO_ROAD1_FRONT [8] = '{8'h81, 8'h81, 8'h81, 8'h8f,
                                                  8'h00, 8'h00, 8'h00, 8'h80};

  typedef struct packed {
    logic               ram_we;
    logic [BANK_AW-1:0] ram_addr;
    logic [15:0]        ram_data;
    logic               rom_we;
    logic [ROM_AW-1:0]  rom_addr;
    logic [7:0]         rom_data;
  } mem_wr_t;

  function automatic logic [10:0] road_color(logic road, logic [2:0] pix,
                                             logic [11:0] cw, logic ext_road);
    logic [3:0]  nib;
    logic [10:0] base;
    logic [10:0] res;
    nib  = road ? cw[7:4] : cw[3:0];
    base = road ? 11'h408 : 11'h400;
    case (pix)
      3'd0: res = base ^ {10'd0, nib[0]};
      3'd1: res = (base ^ 11'h002) ^ {10'd0, nib[1]};
      3'd2: res = (base ^ 11'h004) ^ {10'd0, nib[2]};
      3'd3: begin
        if (ext_road) res = base ^ {10'd0, nib[0]};
        else res = (11'h420 ^ (road ? 11'h010 : 11'h000)) ^ {7'd0, cw[11:8]};
      end
      default: res = (base ^ 11'h006) ^ {10'd0, nib[3]};
    endcase
    return res;
  endfunction

endpackage

@@ rtl/drl_ram.sv @@
// generic memory: one write port, two registered read ports
module drl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

@@ rtl/drl_cfg.sv @@
// apb-style register port for road control and horizontal offset
module drl_cfg import drl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [2:0]  road_ctl,
  output logic [9:0]  x_offset
);

  logic [2:0] ctrl_r, ctrl_nxt;
  logic [9:0] xoff_r, xoff_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    ctrl_nxt = ctrl_r;
    xoff_nxt = xoff_r;
    if (wr_en) begin
      case (paddr[2])
        REG_CONTROL: ctrl_nxt = pwdata[2:0];
        REG_XOFFSET: xoff_nxt = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
      xoff_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
      xoff_r <= xoff_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CONTROL: prdata = {29'd0, ctrl_r};
      REG_XOFFSET: prdata = {22'd0, xoff_r};
      default:     prdata = '0;
    endcase
  end

  assign road_ctl = ctrl_r;
  assign x_offset = xoff_r;

endmodule

@@ rtl/drl_pipe.sv @@
// render pipeline: line table read, scroll and color fetch, rom fetch, priority merge
module drl_pipe import drl_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc_render,
  input  logic [7:0]    line,
  input  logic [8:0]    column,
  input  logic          rd_bank,
  input  mem_wr_t       mem_wr,
  input  logic [2:0]    road_ctl,
  input  logic [9:0]    x_offset,
  input  logic          out_ready,
  output logic          adv,
  output logic          out_valid,
  output logic [10:0]   pixel_color,
  output logic          pixel_drawn
);

  // stage 0: line table reads
  logic [BANK_AW-1:0] ra_addr0, ra_addr1;
  logic [15:0]        d0, d1;

  assign ra_addr0 = {rd_bank, 3'b000, line};
  assign ra_addr1 = {rd_bank, 3'b001, line};

  drl_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_ram_line (
    .clk(clk), .we(mem_wr.ram_we), .waddr(mem_wr.ram_addr), .wdata(mem_wr.ram_data),
    .re(adv), .raddr_a(ra_addr0), .raddr_b(ra_addr1), .rdata_a(d0), .rdata_b(d1)
  );

  logic       v1_r;
  logic [7:0] y1_r;
  logic [8:0] x1_r;
  logic       inr1_r;
  logic       rbank1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= acc_render;
    if (adv) begin
      y1_r     <= line;
      x1_r     <= column;
      inr1_r   <= ({1'b0, column} < 10'(LINE_WIDTH));
      rbank1_r <= rd_bank;
    end
  end

  // stage 1: solid lines, background, second table reads
  mode_t       mode;
  logic        direct, s0, s1, early1;
  logic [8:0]  i0, i1;
  logic [10:0] bg_col1;
  logic        bg_drawn1;
  logic [BANK_AW-1:0] rb_addr0, rb_addr1, rc_addr0, rc_addr1;
  logic [15:0] w0, w1, c0, c1;

  assign mode   = mode_t'(road_ctl[1:0]);
  assign direct = road_ctl[2];
  assign s0     = d0[11];
  assign s1     = d1[11];
  assign i0     = direct ? {1'b0, y1_r} : d0[8:0];
  assign i1     = direct ? {1'b1, y1_r} : d1[8:0];
  assign rb_addr0 = {rbank1_r, 2'b01, i0};
  assign rb_addr1 = {rbank1_r, 2'b10, i1};
  assign rc_addr0 = {rbank1_r, 2'b11, i0};
  assign rc_addr1 = {rbank1_r, 2'b11, i1};
  assign early1 = (s0 && s1) || (mode == MODE_ROAD0 && s0) || (mode == MODE_ROAD1 && s1);

  always_comb begin
    bg_col1   = '0;
    bg_drawn1 = 1'b0;
    case (mode)
      MODE_ROAD0: if (s0) begin
        bg_col1 = {4'hf, d0[6:0]}; bg_drawn1 = 1'b1;
      end
      MODE_ROAD1: if (s1) begin
        bg_col1 = {4'hf, d1[6:0]}; bg_drawn1 = 1'b1;
      end
      MODE_ROAD0_FRONT: if (s0 || s1) begin
        bg_col1 = {4'hf, s0 ? d0[6:0] : d1[6:0]}; bg_drawn1 = 1'b1;
      end
      MODE_ROAD1_FRONT: if (s0 || s1) begin
        bg_col1 = {4'hf, s1 ? d1[6:0] : d0[6:0]}; bg_drawn1 = 1'b1;
      end
      default: ;
    endcase
  end

  drl_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_ram_hpos (
    .clk(clk), .we(mem_wr.ram_we), .waddr(mem_wr.ram_addr), .wdata(mem_wr.ram_data),
    .re(adv), .raddr_a(rb_addr0), .raddr_b(rb_addr1), .rdata_a(w0), .rdata_b(w1)
  );

  drl_ram #(.WIDTH(16), .DEPTH(BANK_DEPTH)) u_ram_cw (
    .clk(clk), .we(mem_wr.ram_we), .waddr(mem_wr.ram_addr), .wdata(mem_wr.ram_data),
    .re(adv), .raddr_a(rc_addr0), .raddr_b(rc_addr1), .rdata_a(c0), .rdata_b(c1)
  );

  logic        v2_r, inr2_r, early2_r, bgd2_r, s0_2_r, s1_2_r, ext0_2_r, ext1_2_r;
  logic [8:0]  x2_r;
  logic [10:0] bgc2_r;
  logic [7:0]  rl0_2_r, rl1_2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
    if (adv) begin
      inr2_r   <= inr1_r;
      early2_r <= early1;
      bgd2_r   <= bg_drawn1;
      bgc2_r   <= bg_col1;
      s0_2_r   <= s0;
      s1_2_r   <= s1;
      ext0_2_r <= d0[9];
      ext1_2_r <= d1[9];
      rl0_2_r  <= d0[8:1];
      rl1_2_r  <= d1[8:1];
      x2_r     <= x1_r;
    end
  end

  // stage 2: scroll position and rom fetch
  logic [11:0] shift, h0, h1;
  logic [ROM_AW-1:0] r0_lo, r0_hi, r1_lo, r1_hi;
  logic [7:0] b0_lo, b0_hi, b1_lo, b1_hi;

  assign shift = SCROLL_BASE + {2'b00, x_offset};
  assign h0    = w0[11:0] - shift + {3'b000, x2_r};
  assign h1    = w1[11:0] - shift + {3'b000, x2_r};
  assign r0_lo = {2'b00, rl0_2_r, h0[8:3]};
  assign r0_hi = {2'b01, rl0_2_r, h0[8:3]};
  assign r1_lo = {ROM_HI, 1'b0, rl1_2_r, h1[8:3]};
  assign r1_hi = {ROM_HI, 1'b1, rl1_2_r, h1[8:3]};

  drl_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom_road0 (
    .clk(clk), .we(mem_wr.rom_we), .waddr(mem_wr.rom_addr), .wdata(mem_wr.rom_data),
    .re(adv), .raddr_a(r0_lo), .raddr_b(r0_hi), .rdata_a(b0_lo), .rdata_b(b0_hi)
  );

  drl_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom_road1 (
    .clk(clk), .we(mem_wr.rom_we), .waddr(mem_wr.rom_addr), .wdata(mem_wr.rom_data),
    .re(adv), .raddr_a(r1_lo), .raddr_b(r1_hi), .rdata_a(b1_lo), .rdata_b(b1_hi)
  );

  logic        v3_r, inr3_r, early3_r, bgd3_r, ext0_3_r, ext1_3_r;
  logic        out0_3_r, out1_3_r, str0_3_r, str1_3_r;
  logic [2:0]  sel0_3_r, sel1_3_r;
  logic [10:0] bgc3_r;
  logic [11:0] c0_3_r, c1_3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
    if (adv) begin
      inr3_r   <= inr2_r;
      early3_r <= early2_r;
      bgd3_r   <= bgd2_r;
      bgc3_r   <= bgc2_r;
      ext0_3_r <= ext0_2_r;
      ext1_3_r <= ext1_2_r;
      // solid line or beyond the road's width reads as exterior
      out0_3_r <= s0_2_r || (h0[11:9] != 3'd0);
      out1_3_r <= s1_2_r || (h1[11:9] != 3'd0);
      str0_3_r <= (h0[8:3] == 6'd31);
      str1_3_r <= (h1[8:3] == 6'd31);
      sel0_3_r <= ~h0[2:0];
      sel1_3_r <= ~h1[2:0];
      c0_3_r   <= c0[11:0];
      c1_3_r   <= c1[11:0];
    end
  end

  // stage 3: pixel decode and priority
  logic [1:0]  v0, v1;
  logic [2:0]  p0, p1;
  logic [10:0] col0, col1, col3;
  logic        drawn3, front1;
  logic [7:0]  prio_row;

  assign v0 = {b0_hi[sel0_3_r], b0_lo[sel0_3_r]};
  assign v1 = {b1_hi[sel1_3_r], b1_lo[sel1_3_r]};
  assign p0 = out0_3_r ? 3'd3 : ((v0 == 2'd3 && str0_3_r) ? 3'd7 : {1'b0, v0});
  assign p1 = out1_3_r ? 3'd3 : ((v1 == 2'd3 && str1_3_r) ? 3'd7 : {1'b0, v1});
  assign col0 = road_color(1'b0, p0, c0_3_r, ext0_3_r);
  assign col1 = road_color(1'b1, p1, c1_3_r, ext1_3_r);
  assign prio_row = (mode == MODE_ROAD1_FRONT) ? PRIO_ROAD1_FRONT[p0] : PRIO_ROAD0_FRONT[p0];
  assign front1   = prio_row[p1];

  always_comb begin
    col3   = '0;
    drawn3 = 1'b0;
    if (inr3_r) begin
      if (early3_r) begin
        col3   = bgc3_r;
        drawn3 = bgd3_r;
      end else begin
        drawn3 = 1'b1;
        case (mode)
          MODE_ROAD0: col3 = col0;
          MODE_ROAD1: col3 = col1;
          default:    col3 = front1 ? col1 : col0;
        endcase
      end
    end
  end

  // output register
  logic        out_valid_r;
  logic [10:0] col_r;
  logic        drawn_r;

  assign adv = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= v3_r;
    if (adv) begin
      col_r   <= col3;
      drawn_r <= drawn3;
    end
  end

  assign out_valid   = out_valid_r;
  assign pixel_color = col_r;
  assign pixel_drawn = drawn_r;

endmodule

@@ rtl/dual_road_layer_pixel_renderer_unit.sv @@
// Two-road pixel renderer: each accepted render request gives one pixel, and the pipeline
// takes one request per clock whenever its output register can move on (line table read,
// scroll and color word read, rom fetch, priority merge, output register); ram writes, bank
// swaps and rom loads are taken likewise, one per clock, with no result. After reset all 4096
// road ram words are cleared one per clock through its single write port; in_ready stays low.
module dual_road_layer_pixel_renderer_unit import drl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [10:0] in_ram_word_addr,
  input  logic [15:0] in_ram_word_data,
  input  logic [15:0] in_rom_byte_addr,
  input  logic [7:0]  in_rom_byte_data,
  input  logic [7:0]  in_line,
  input  logic [8:0]  in_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_pixel_color,
  output logic        out_pixel_drawn,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [2:0] road_ctl;
  logic [9:0] x_offset;

  drl_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata), .pready(cfg_pready),
    .road_ctl(road_ctl), .x_offset(x_offset)
  );

  logic               bank_r, bank_nxt;
  logic               clearing_r, clearing_nxt;
  logic [BANK_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic               adv, acc;
  cmd_t               cmd;
  mem_wr_t            mem_wr;
  logic               rom_pend_r;
  logic [ROM_AW-1:0]  rom_addr_r;
  logic [7:0]         rom_data_r;

  assign cmd      = cmd_t'(in_cmd);
  assign in_ready = adv && !clearing_r;
  assign acc      = in_valid && in_ready;

  always_comb begin
    bank_nxt     = bank_r;
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == BANK_AW'(BANK_DEPTH - 1)) clearing_nxt = 1'b0;
    end
    if (acc && cmd == CMD_SWAP) bank_nxt = ~bank_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r     <= 1'b0;
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      bank_r     <= bank_nxt;
      clearing_r <= clearing_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // a rom load lands with the next pipeline step, so renders ahead of it still read the old byte
  always_ff @(posedge clk) begin
    if (!rst_n) rom_pend_r <= 1'b0;
    else if (adv) rom_pend_r <= acc && cmd == CMD_LOAD_ROM;
    if (adv) begin
      rom_addr_r <= in_rom_byte_addr;
      rom_data_r <= in_rom_byte_data;
    end
  end

  always_comb begin
    if (clearing_r) begin
      mem_wr.ram_we   = 1'b1;
      mem_wr.ram_addr = clr_cnt_r;
      mem_wr.ram_data = '0;
    end else begin
      mem_wr.ram_we   = acc && cmd == CMD_WRITE_RAM;
      mem_wr.ram_addr = {bank_r, in_ram_word_addr};
      mem_wr.ram_data = in_ram_word_data;
    end
    mem_wr.rom_we   = rom_pend_r && adv;
    mem_wr.rom_addr = rom_addr_r;
    mem_wr.rom_data = rom_data_r;
  end

  drl_pipe u_pipe (
    .clk(clk), .rst_n(rst_n), .acc_render(acc && cmd == CMD_RENDER),
    .line(in_line), .column(in_column), .rd_bank(~bank_r), .mem_wr(mem_wr),
    .road_ctl(road_ctl), .x_offset(x_offset), .out_ready(out_ready),
    .adv(adv), .out_valid(out_valid), .pixel_color(out_pixel_color),
    .pixel_drawn(out_pixel_drawn)
  );

endmodule
